// ===== src/zot_pkg.sv =====
// ----------------------------------------------------------------------------
// zot_pkg - zone occupancy tracker package
// Request, status and register codes, default sizes and the status and step functions.
// ----------------------------------------------------------------------------
package zot_pkg;

	localparam int unsigned MAX_ZONES_D     = 8;
	localparam int unsigned MAX_SLOTS_D     = 3;
	localparam int unsigned DETECTOR_BITS_D = 8;

	localparam logic [1:0] REQ_SETUP = 2'd0;
	localparam logic [1:0] REQ_MAP   = 2'd1;
	localparam logic [1:0] REQ_EVENT = 2'd2;

	localparam logic [1:0] ST_PART  = 2'd0;
	localparam logic [1:0] ST_FULL  = 2'd1;
	localparam logic [1:0] ST_EMPTY = 2'd2;

	localparam logic CFG_LEVEL_CAP = 1'b0;
	localparam logic CFG_ZONES     = 1'b1;

	localparam logic signed [15:0] OCC_MAX = 16'sh7FFF;
	localparam logic signed [15:0] OCC_MIN = -16'sh8000;

	typedef struct packed {
		logic [1:0]  status;
		logic [15:0] free;
	} stat_t;

	function automatic stat_t status_of(input logic [15:0] cap, input logic signed [15:0] occ);
		stat_t r;
		logic signed [17:0] fr;
		fr = $signed({2'b00, cap}) - $signed({{2{occ[15]}}, occ});
		r.free = '0;
		if (fr <= 18'sd0) begin
			r.status = ST_FULL;
		end else if (occ <= 16'sd0) begin
			r.status = ST_EMPTY;
		end else begin
			r.status = ST_PART;
			r.free   = fr[15:0];
		end
		return r;
	endfunction

	function automatic logic signed [15:0] sat_step(input logic signed [15:0] occ, input logic up);
		logic signed [15:0] r;
		r = occ;
		if (up) begin
			if (occ != OCC_MAX) r = occ + 16'sd1;
		end else begin
			if (occ != OCC_MIN) r = occ - 16'sd1;
		end
		return r;
	endfunction

endpackage

// ===== src/zone_occupancy_tracker.sv =====
// ----------------------------------------------------------------------------
// zone_occupancy_tracker - parking zone and level occupancy from detector events
// Scans entry then exit detector maps over the zones in use, one slot at a time.
// ----------------------------------------------------------------------------
// Setup and map writes give no word.
// An event keeps busy high while both maps are scanned: each slot in use is read
// from the map RAM and compared, and each match steps the zone and level counts.
// Zone words come while busy; the level word (last) comes in the first idle cycle.
// Reset clears counts, capacities, slot counts and registers; the maps are not cleared.
module zone_occupancy_tracker import zot_pkg::*; #(
	parameter int MAX_ZONES     = MAX_ZONES_D,
	parameter int MAX_SLOTS     = MAX_SLOTS_D,
	parameter int DETECTOR_BITS = DETECTOR_BITS_D
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	output logic        busy,
	input  logic [1:0]  req_type,
	input  logic [2:0]  zone_index,
	input  logic [1:0]  slot_index,
	input  logic        is_exit,
	input  logic [7:0]  detector_id,
	input  logic [15:0] zone_capacity_in,
	input  logic [1:0]  entry_count_in,
	input  logic [1:0]  exit_count_in,
	input  logic [8:0]  signal_code,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic        cfg_index,
	input  logic [15:0] cfg_data,
	output logic        strobe,
	output logic        scope,
	output logic [2:0]  status_zone,
	output logic [1:0]  status,
	output logic [15:0] free_spaces,
	output logic        last
);

	localparam int ZW        = (MAX_ZONES > 1) ? $clog2(MAX_ZONES) : 1;
	localparam int ZCW       = $clog2(MAX_ZONES + 1);
	localparam int SCW       = $clog2(MAX_SLOTS + 1);
	localparam int MAP_DEPTH = MAX_ZONES * MAX_SLOTS;
	localparam int RAM_DEPTH = 2 * MAP_DEPTH;
	localparam int AW        = $clog2(RAM_DEPTH);
	localparam int DW        = DETECTOR_BITS;
	localparam int CMPW      = (DW > 9) ? DW : 9;

	localparam logic [AW-1:0]  SLOTS_A = AW'(MAX_SLOTS);
	localparam logic [AW-1:0]  MAPD_A  = AW'(MAP_DEPTH);
	localparam logic [SCW-1:0] SLOTS_C = SCW'(MAX_SLOTS);
	localparam logic [ZCW-1:0] ZONES_C = ZCW'(MAX_ZONES);

	typedef enum logic [2:0] {
		S_IDLE, S_NEXT, S_CMP, S_ADJ, S_EMIT, S_LEVEL
	} state_t;

	state_t state_q;

	logic [15:0]        level_cap_q;
	logic [3:0]         zones_q;
	logic [15:0]        cap_q [MAX_ZONES];
	logic signed [15:0] occ_q [MAX_ZONES];
	logic [SCW-1:0]     ent_cnt_q [MAX_ZONES];
	logic [SCW-1:0]     ext_cnt_q [MAX_ZONES];
	logic signed [15:0] lvl_occ_q;

	logic           pass_q;
	logic           fwd_q;
	logic [8:0]     det_q;
	logic [ZCW-1:0] nz_q;
	logic [ZCW-1:0] zone_q;
	logic [SCW-1:0] slot_q;

	logic        strobe_q;
	logic        scope_q;
	logic [2:0]  status_zone_q;
	logic [1:0]  status_q;
	logic [15:0] free_q;
	logic        last_q;

	logic          accept;
	logic          zone_ok;
	logic          slot_ok;
	logic [ZW-1:0] zi_in;
	logic [ZW-1:0] zi;
	logic [SCW-1:0] cnt_cur;
	logic [SCW-1:0] ent_clamp;
	logic [SCW-1:0] ext_clamp;
	logic [8:0]     det_in;
	logic [ZCW-1:0] nz_in;
	logic           map_we;
	logic [AW-1:0]  map_waddr;
	logic [DW-1:0]  map_wdata;
	logic           map_re;
	logic [AW-1:0]  map_raddr;
	logic [DW-1:0]  map_rdata;
	logic           hit;
	stat_t          zone_st;
	stat_t          lvl_st;

	assign busy      = (state_q != S_IDLE);
	assign cfg_ready = !busy;
	assign accept    = start && !busy;

	always_comb begin
		zone_ok   = (32'(zone_index) < MAX_ZONES);
		slot_ok   = (32'(slot_index) < MAX_SLOTS);
		zi_in     = ZW'(zone_index);
		zi        = ZW'(zone_q);
		cnt_cur   = pass_q ? ext_cnt_q[zi] : ent_cnt_q[zi];
		ent_clamp = (32'(entry_count_in) > MAX_SLOTS) ? SLOTS_C : SCW'(entry_count_in);
		ext_clamp = (32'(exit_count_in) > MAX_SLOTS) ? SLOTS_C : SCW'(exit_count_in);
		det_in    = signal_code[0] ? 9'((10'(signal_code) + 10'd1) >> 1) : (signal_code >> 1);
		nz_in     = (32'(zones_q) > MAX_ZONES) ? ZONES_C : ZCW'(zones_q);
		map_we    = accept && (req_type == REQ_MAP) && zone_ok && slot_ok;
		map_waddr = AW'(is_exit) * MAPD_A + AW'(zone_index) * SLOTS_A + AW'(slot_index);
		map_wdata = DW'(detector_id);
		map_re    = (state_q == S_NEXT) && (zone_q < nz_q) && (slot_q < cnt_cur);
		map_raddr = AW'(pass_q) * MAPD_A + AW'(zone_q) * SLOTS_A + AW'(slot_q);
		hit       = (CMPW'(map_rdata) == CMPW'(det_q));
		zone_st   = status_of(cap_q[zi], occ_q[zi]);
		lvl_st    = status_of(level_cap_q, lvl_occ_q);
	end

	zot_ram #(
		.WIDTH(DW),
		.DEPTH(RAM_DEPTH)
	) u_map (
		.clk  (clk),
		.we   (map_we),
		.waddr(map_waddr),
		.wdata(map_wdata),
		.re   (map_re),
		.raddr(map_raddr),
		.rdata(map_rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q       <= S_IDLE;
			level_cap_q   <= '0;
			zones_q       <= '0;
			lvl_occ_q     <= '0;
			pass_q        <= 1'b0;
			fwd_q         <= 1'b0;
			det_q         <= '0;
			nz_q          <= '0;
			zone_q        <= '0;
			slot_q        <= '0;
			strobe_q      <= 1'b0;
			scope_q       <= 1'b0;
			status_zone_q <= '0;
			status_q      <= '0;
			free_q        <= '0;
			last_q        <= 1'b0;
			for (int i = 0; i < MAX_ZONES; i++) begin
				cap_q[i]     <= '0;
				occ_q[i]     <= '0;
				ent_cnt_q[i] <= '0;
				ext_cnt_q[i] <= '0;
			end
		end else begin
			strobe_q <= 1'b0;
			if (cfg_valid && cfg_ready) begin
				unique case (cfg_index)
					CFG_LEVEL_CAP: level_cap_q <= cfg_data;
					CFG_ZONES:     zones_q     <= cfg_data[3:0];
					default:       ;
				endcase
			end
			unique case (state_q)
				S_IDLE: begin
					if (accept && (req_type == REQ_SETUP) && zone_ok) begin
						cap_q[zi_in]     <= zone_capacity_in;
						ent_cnt_q[zi_in] <= ent_clamp;
						ext_cnt_q[zi_in] <= ext_clamp;
					end
					if (accept && (req_type == REQ_EVENT)) begin
						fwd_q   <= signal_code[0];
						det_q   <= det_in;
						nz_q    <= nz_in;
						pass_q  <= 1'b0;
						zone_q  <= '0;
						slot_q  <= '0;
						state_q <= S_NEXT;
					end
				end
				S_NEXT: begin
					if (zone_q >= nz_q) begin
						if (!pass_q) begin
							pass_q <= 1'b1;
							zone_q <= '0;
							slot_q <= '0;
						end else begin
							state_q <= S_LEVEL;
						end
					end else if (slot_q >= cnt_cur) begin
						zone_q <= zone_q + ZCW'(1);
						slot_q <= '0;
					end else begin
						state_q <= S_CMP;
					end
				end
				S_CMP: begin
					if (hit) begin
						state_q <= S_ADJ;
					end else begin
						slot_q  <= slot_q + SCW'(1);
						state_q <= S_NEXT;
					end
				end
				S_ADJ: begin
					occ_q[zi] <= sat_step(occ_q[zi], fwd_q ^ pass_q);
					lvl_occ_q <= sat_step(lvl_occ_q, fwd_q ^ pass_q);
					state_q   <= S_EMIT;
				end
				S_EMIT: begin
					strobe_q      <= 1'b1;
					scope_q       <= 1'b0;
					status_zone_q <= 3'(zone_q);
					status_q      <= zone_st.status;
					free_q        <= zone_st.free;
					last_q        <= 1'b0;
					slot_q        <= slot_q + SCW'(1);
					state_q       <= S_NEXT;
				end
				S_LEVEL: begin
					strobe_q      <= 1'b1;
					scope_q       <= 1'b1;
					status_zone_q <= '0;
					status_q      <= lvl_st.status;
					free_q        <= lvl_st.free;
					last_q        <= 1'b1;
					state_q       <= S_IDLE;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	assign strobe      = strobe_q;
	assign scope       = scope_q;
	assign status_zone = status_zone_q;
	assign status      = status_q;
	assign free_spaces = free_q;
	assign last        = last_q;

	a_last_is_level: assert property (@(posedge clk) disable iff (!arst_n)
		strobe && last |-> scope && !busy)
		else $error("last word is not an idle level word");

	a_zone_word_busy: assert property (@(posedge clk) disable iff (!arst_n)
		strobe && !last |-> busy && !scope)
		else $error("zone word outside a scan");

	a_free_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		strobe && (status == ST_PART) |-> free_spaces != 16'd0)
		else $error("partly free word with no free spaces");

	a_event_busy: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy && (req_type == REQ_EVENT) |=> busy)
		else $error("event did not start a scan");

	a_cfg_idle: assert property (@(posedge clk) disable iff (!arst_n)
		busy |-> !cfg_ready)
		else $error("register write taken during a scan");

endmodule

// ===== src/zot_ram.sv =====
// ----------------------------------------------------------------------------
// zot_ram - generic simple dual-port RAM
// One write port, one read port with registered read data.
// ----------------------------------------------------------------------------
module zot_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 2
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) mem_q[waddr] <= wdata;
		if (re) rdata <= mem_q[raddr];
	end

endmodule

// ===== sim/zone_occupancy_tracker_test.sv =====
// ----------------------------------------------------------------------------
// zone_occupancy_tracker_test - self-checking bench for the occupancy tracker
// Drives setup, map and detector-event commands through the start/busy port.
// A shadow of capacities, slot maps and counts predicts every zone and level
// status word, and the monitor compares each strobed word field by field.
// Phases vary both registers and the sender's gap rate.
// ----------------------------------------------------------------------------
module zone_occupancy_tracker_test;
	import zot_pkg::*;

	localparam int ZONES          = MAX_ZONES_D;
	localparam int SLOTS          = MAX_SLOTS_D;
	localparam int MAP_WORDS      = ZONES * SLOTS;
	localparam logic [1:0] REQ_SPARE = 2'd3;
	localparam logic SCOPE_ZONE   = 1'b0;
	localparam logic SCOPE_LEVEL  = 1'b1;
	localparam int SETTLE_CYCLES  = 256;
	localparam int DRAIN_LIMIT    = 1000;
	localparam int RUN_LIMIT      = 3_000_000;
	localparam int MISS_PRINT_MAX = 30;

	typedef struct packed {
		logic [1:0]  req_type;
		logic [2:0]  zone_index;
		logic [1:0]  slot_index;
		logic        is_exit;
		logic [7:0]  detector_id;
		logic [15:0] zone_capacity_in;
		logic [1:0]  entry_count_in;
		logic [1:0]  exit_count_in;
		logic [8:0]  signal_code;
	} cmd_word_t;

	typedef struct packed {
		logic        scope;
		logic [2:0]  status_zone;
		logic [1:0]  status;
		logic [15:0] free_spaces;
		logic        last;
	} status_word_t;

	logic        clk       = 1'b0;
	logic        arst_n    = 1'b0;
	logic        start     = 1'b0;
	logic        busy;
	cmd_word_t   cmd       = '0;
	logic        cfg_valid = 1'b0;
	logic        cfg_ready;
	logic        cfg_index = 1'b0;
	logic [15:0] cfg_data  = '0;
	logic        strobe;
	logic        scope;
	logic [2:0]  status_zone;
	logic [1:0]  status;
	logic [15:0] free_spaces;
	logic        last;

	zone_occupancy_tracker dut (
		.clk              (clk),
		.arst_n           (arst_n),
		.start            (start),
		.busy             (busy),
		.req_type         (cmd.req_type),
		.zone_index       (cmd.zone_index),
		.slot_index       (cmd.slot_index),
		.is_exit          (cmd.is_exit),
		.detector_id      (cmd.detector_id),
		.zone_capacity_in (cmd.zone_capacity_in),
		.entry_count_in   (cmd.entry_count_in),
		.exit_count_in    (cmd.exit_count_in),
		.signal_code      (cmd.signal_code),
		.cfg_valid        (cfg_valid),
		.cfg_ready        (cfg_ready),
		.cfg_index        (cfg_index),
		.cfg_data         (cfg_data),
		.strobe           (strobe),
		.scope            (scope),
		.status_zone      (status_zone),
		.status           (status),
		.free_spaces      (free_spaces),
		.last             (last)
	);

	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	// shadow of the block
	logic [15:0]  lvl_cap_cfg = '0;
	logic [3:0]   zones_cfg   = '0;
	logic [15:0]  zone_cap   [ZONES]     = '{default: '0};
	int           zone_occ   [ZONES]     = '{default: 0};
	int           zone_ent_n [ZONES]     = '{default: 0};
	int           zone_ext_n [ZONES]     = '{default: 0};
	logic [7:0]   entry_det  [MAP_WORDS] = '{default: '0};
	logic [7:0]   exit_det   [MAP_WORDS] = '{default: '0};
	int           level_occ   = 0;
	status_word_t status_due [$];

	// stimulus side
	cmd_word_t    pending_cmds [$];
	int           gen_ent_n    [ZONES]     = '{default: 0};
	int           gen_ext_n    [ZONES]     = '{default: 0};
	bit           gen_entry_set [MAP_WORDS] = '{default: 1'b0};
	bit           gen_exit_set  [MAP_WORDS] = '{default: 1'b0};
	int           gen_zones     = 0;
	int           send_idle_pct = 0;
	logic [7:0]   det_pool [8] = '{8'd0, 8'd1, 8'd2, 8'd3, 8'd85, 8'd170, 8'd254, 8'd255};

	int words_taken = 0;
	int events_done = 0;
	int words_seen  = 0;
	int miss_count  = 0;
	int cycle_count = 0;

	status_word_t seen_word, due_word;
	assign seen_word = {scope, status_zone, status, free_spaces, last};

	task automatic flag_miss(input string what, input int got, input int want);
		miss_count++;
		if (miss_count <= MISS_PRINT_MAX)
			$display("MISMATCH %0s: got %0d expected %0d (cycle %0d)", what, got, want,
				cycle_count);
	endtask

	function automatic int bump_count(input int v, input int d);
		int r;
		r = v + d;
		if (r > int'(OCC_MAX)) r = int'(OCC_MAX);
		if (r < int'(OCC_MIN)) r = int'(OCC_MIN);
		return r;
	endfunction

	function automatic status_word_t occupancy_word(input logic sc, input int zn,
			input logic [15:0] cap, input int occ, input logic lst);
		status_word_t w;
		int spare;
		spare = int'(cap) - occ;
		w.scope       = sc;
		w.status_zone = zn[2:0];
		w.last        = lst;
		w.free_spaces = '0;
		if (spare <= 0) begin
			w.status = ST_FULL;
		end else if (spare >= int'(cap)) begin
			w.status = ST_EMPTY;
		end else begin
			w.status      = ST_PART;
			w.free_spaces = spare[15:0];
		end
		return w;
	endfunction

	function automatic void move_zone(input int z, input int d);
		zone_occ[z] = bump_count(zone_occ[z], d);
		level_occ   = bump_count(level_occ, d);
		status_due.push_back(occupancy_word(SCOPE_ZONE, z, zone_cap[z], zone_occ[z], 1'b0));
	endfunction

	function automatic void track_word(input cmd_word_t c);
		int z, a, det, dir, nz;
		z = c.zone_index;
		case (c.req_type)
			REQ_SETUP: begin
				if (z < ZONES) begin
					zone_cap[z]   = c.zone_capacity_in;
					zone_ent_n[z] = c.entry_count_in > SLOTS ? SLOTS : c.entry_count_in;
					zone_ext_n[z] = c.exit_count_in > SLOTS ? SLOTS : c.exit_count_in;
				end
			end
			REQ_MAP: begin
				if (z < ZONES && c.slot_index < SLOTS) begin
					a = z * SLOTS + c.slot_index;
					if (c.is_exit) exit_det[a] = c.detector_id;
					else entry_det[a] = c.detector_id;
				end
			end
			REQ_EVENT: begin
				dir = c.signal_code[0] ? 1 : -1;
				det = c.signal_code[0] ? (int'(c.signal_code) + 1) / 2 : int'(c.signal_code) / 2;
				nz  = zones_cfg > ZONES ? ZONES : zones_cfg;
				for (int i = 0; i < nz; i++)
					for (int j = 0; j < zone_ent_n[i] && j < SLOTS; j++)
						if (int'(entry_det[i * SLOTS + j]) == det) move_zone(i, dir);
				for (int i = 0; i < nz; i++)
					for (int j = 0; j < zone_ext_n[i] && j < SLOTS; j++)
						if (int'(exit_det[i * SLOTS + j]) == det) move_zone(i, -dir);
				status_due.push_back(occupancy_word(SCOPE_LEVEL, 0, lvl_cap_cfg, level_occ, 1'b1));
				events_done++;
			end
			default: ;
		endcase
	endfunction

	function automatic cmd_word_t random_word();
		logic [63:0] r;
		r = {$urandom, $urandom};
		return r[$bits(cmd_word_t)-1:0];
	endfunction

	function automatic void queue_word(input cmd_word_t c);
		int a;
		a = c.zone_index * SLOTS + c.slot_index;
		pending_cmds.push_back(c);
		if (c.req_type == REQ_SETUP) begin
			gen_ent_n[c.zone_index] = c.entry_count_in > SLOTS ? SLOTS : c.entry_count_in;
			gen_ext_n[c.zone_index] = c.exit_count_in > SLOTS ? SLOTS : c.exit_count_in;
		end else if (c.req_type == REQ_MAP && c.slot_index < SLOTS) begin
			if (c.is_exit) gen_exit_set[a] = 1'b1;
			else gen_entry_set[a] = 1'b1;
		end
	endfunction

	function automatic void queue_setup(input int z, input logic [15:0] cap, input int ent,
			input int ext);
		cmd_word_t c;
		c = random_word();
		c.req_type         = REQ_SETUP;
		c.zone_index       = z[2:0];
		c.zone_capacity_in = cap;
		c.entry_count_in   = ent[1:0];
		c.exit_count_in    = ext[1:0];
		queue_word(c);
	endfunction

	function automatic void queue_map(input int z, input int s, input logic x,
			input logic [7:0] d);
		cmd_word_t c;
		c = random_word();
		c.req_type    = REQ_MAP;
		c.zone_index  = z[2:0];
		c.slot_index  = s[1:0];
		c.is_exit     = x;
		c.detector_id = d;
		queue_word(c);
	endfunction

	// write any slot the event will scan that has never been written
	function automatic void queue_event(input logic [8:0] code);
		cmd_word_t c;
		for (int i = 0; i < gen_zones; i++)
			for (int j = 0; j < SLOTS; j++) begin
				if (j < gen_ent_n[i] && !gen_entry_set[i * SLOTS + j])
					queue_map(i, j, 1'b0, det_pool[$urandom_range(7)]);
				if (j < gen_ext_n[i] && !gen_exit_set[i * SLOTS + j])
					queue_map(i, j, 1'b1, det_pool[$urandom_range(7)]);
			end
		c = random_word();
		c.req_type    = REQ_EVENT;
		c.signal_code = code;
		queue_word(c);
	endfunction

	function automatic logic [8:0] code_for(input logic [7:0] d, input logic fwd);
		if (d == 8'd0 || !fwd) return {d, 1'b0};
		return {d, 1'b0} - 9'd1;
	endfunction

	function automatic logic [15:0] pick_capacity();
		int r;
		r = $urandom_range(9);
		if (r == 0) return 16'd0;
		if (r == 1) return 16'hFFFF;
		if (r < 4) return 16'($urandom);
		return 16'($urandom_range(40));
	endfunction

	function automatic void queue_random(input int n);
		int made, pick;
		cmd_word_t c;
		made = 0;
		while (made < n) begin
			pick = $urandom_range(99);
			c = random_word();
			if (pick < 58) begin
				queue_event(code_for(det_pool[$urandom_range(7)], 1'($urandom_range(1))));
				made++;
			end else if (pick < 66) begin
				queue_event(c.signal_code);
				made++;
			end else if (pick < 80) begin
				queue_map($urandom_range(ZONES - 1), $urandom_range(SLOTS - 1),
					1'($urandom_range(1)), det_pool[$urandom_range(7)]);
				made++;
			end else if (pick < 84) begin
				c.req_type = REQ_MAP;
				queue_word(c);
				if (c.slot_index < SLOTS) made++;
			end else if (pick < 96) begin
				queue_setup($urandom_range(ZONES - 1), pick_capacity(), $urandom_range(3),
					$urandom_range(3));
				made++;
			end else begin
				c.req_type = REQ_SPARE;
				queue_word(c);
			end
		end
	endfunction

	task automatic write_reg(input logic idx, input logic [15:0] val);
		@(posedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= val;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
		if (idx == CFG_LEVEL_CAP) lvl_cap_cfg = val;
		else zones_cfg = val[3:0];
	endtask

	task automatic set_regs(input logic [15:0] cap, input logic [3:0] zones);
		logic [15:0] zword;
		zword = {12'($urandom), zones};
		write_reg(CFG_LEVEL_CAP, cap);
		write_reg(CFG_ZONES, zword);
		gen_zones = zones > ZONES ? ZONES : zones;
	endtask

	task automatic drain();
		int waited;
		while (pending_cmds.size() != 0 || start) @(posedge clk);
		waited = 0;
		while (status_due.size() != 0 && waited < DRAIN_LIMIT) begin
			@(posedge clk);
			waited++;
		end
		repeat (SETTLE_CYCLES) @(posedge clk);
		if (status_due.size() != 0) begin
			flag_miss("status words never seen", 0, status_due.size());
			status_due.delete();
		end
	endtask

	task automatic run_phase(input logic [15:0] cap, input logic [3:0] zones, input int idle,
			input int n);
		drain();
		set_regs(cap, zones);
		send_idle_pct = idle;
		queue_random(n);
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			start <= 1'b0;
		end else begin : drive_blk
			logic go;
			go = start;
			if (start && !busy) begin
				track_word(cmd);
				words_taken++;
				go = 1'b0;
			end
			if (!go && pending_cmds.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
				cmd <= pending_cmds.pop_front();
				go = 1'b1;
			end
			start <= go;
		end
	end

	always @(posedge clk) begin
		if (arst_n && strobe) begin
			if (status_due.size() == 0) begin
				flag_miss("status word with none due", int'(seen_word), 0);
			end else begin
				due_word = status_due.pop_front();
				if (seen_word.scope !== due_word.scope)
					flag_miss("scope", seen_word.scope, due_word.scope);
				if (seen_word.status_zone !== due_word.status_zone)
					flag_miss("status_zone", seen_word.status_zone, due_word.status_zone);
				if (seen_word.status !== due_word.status)
					flag_miss("status", seen_word.status, due_word.status);
				if (seen_word.free_spaces !== due_word.free_spaces)
					flag_miss("free_spaces", seen_word.free_spaces, due_word.free_spaces);
				if (seen_word.last !== due_word.last)
					flag_miss("last", seen_word.last, due_word.last);
			end
			words_seen++;
		end
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count == RUN_LIMIT) begin
			$display("Run stopped at cycle limit with %0d words still due", status_due.size());
			$display("zone_occupancy_tracker test failed");
			$finish;
		end
	end

	initial begin : main_seq
		cmd_word_t c;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;

		set_regs(16'd0, 4'd0);
		queue_event(9'd0);
		c = random_word();
		c.req_type = REQ_SPARE;
		queue_word(c);
		drain();

		set_regs(16'hFFFF, 4'd15);
		queue_setup(7, 16'hFFFF, 3, 3);
		queue_setup(0, 16'd0, 1, 1);
		for (int s = 0; s < SLOTS; s++) begin
			queue_map(7, s, 1'b0, 8'd255);
			queue_map(7, s, 1'b1, 8'd1);
		end
		queue_map(7, 3, 1'b0, 8'd0);
		queue_event(code_for(8'd255, 1'b1));
		queue_event(code_for(8'd255, 1'b0));
		queue_event(code_for(8'd1, 1'b1));
		queue_event(code_for(8'd1, 1'b0));
		queue_event(9'h1FF);
		queue_setup(7, 16'd2, 3, 3);
		queue_event(code_for(8'd255, 1'b1));
		queue_setup(7, 16'd4, 3, 3);
		queue_event(code_for(8'd255, 1'b0));
		queue_event(code_for(8'd255, 1'b1));

		run_phase(16'd40, 4'd8, 0, 115);
		run_phase(16'($urandom), 4'($urandom_range(1, 7)), 62, 115);
		run_phase(16'hFFFF, 4'd12, 0, 115);
		run_phase(16'd25, 4'd4, 16, 115);
		drain();

		$display("Accepted %0d commands, %0d of them detector events; %0d status words checked",
			words_taken, events_done, words_seen);
		$display("Level capacity and zone count swept to both ends, sender gaps 0/16/62 pct");
		if (miss_count == 0) begin
			$display("zone_occupancy_tracker test passed");
		end else begin
			$display("%0d mismatches", miss_count);
			$display("zone_occupancy_tracker test failed");
		end
		$finish;
	end

endmodule

// ===== filelist.f =====
src/zot_pkg.sv
src/zot_ram.sv
src/zone_occupancy_tracker.sv
sim/zone_occupancy_tracker_test.sv
